FILE: rtl/asc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types and constants of the adaptive scene cut detector.
// ----------------------------------------------------------------------------
package asc_pkg;

  localparam int unsigned MAX_HALF_WIDTH = 15;
  localparam int unsigned DEPTH          = 2 * MAX_HALF_WIDTH + 1;
  localparam int unsigned CNT_W          = $clog2(DEPTH + 1);
  // neighbour sum: up to DEPTH-1 scores of 32 bits plus rounding, signed
  localparam int unsigned SUM_W          = 32 + $clog2(DEPTH) + 1;
  localparam int unsigned AVG_W          = 33;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 63;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SCENE_US = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SCORE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO        = 2'd3;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic               metrics_ok;
    logic signed [31:0] frame_score;
    logic [62:0]        frame_time_us;
    logic [47:0]        frame_index;
    logic signed [31:0] luma_delta;
    logic signed [31:0] hue_delta;
    logic signed [31:0] sat_delta;
  } asc_in_t;

  typedef struct packed {
    logic               cut_found;
    logic [62:0]        cut_time_us;
    logic [47:0]        cut_index;
    logic signed [31:0] cut_score;
    logic [30:0]        cut_threshold;
    logic signed [31:0] cut_luma;
    logic signed [31:0] cut_hue;
    logic signed [31:0] cut_sat;
  } asc_out_t;

  typedef struct packed {
    logic signed [31:0] score;
    logic [62:0]        time_us;
    logic [47:0]        index;
    logic signed [31:0] luma;
    logic signed [31:0] hue;
    logic signed [31:0] sat;
  } asc_entry_t;

  typedef struct packed {
    logic shift;
    logic load;
  } asc_cell_ctrl_t;

endpackage

FILE: rtl/asc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_cell
// One window slot: loads a new frame entry or takes its neighbour's entry.
// ----------------------------------------------------------------------------
module asc_cell
  import asc_pkg::*;
(
  input  logic           clk_i,
  input  asc_cell_ctrl_t ctrl_i,
  input  asc_entry_t     next_i,
  input  asc_entry_t     new_i,
  output asc_entry_t     entry_o
);

  asc_entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d = new_i;
    end else if (ctrl_i.shift) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: rtl/asc_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asc_divider
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module asc_divider
  import asc_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [SUM_W-1:0] num_i,
  input  logic [CNT_W-1:0]        den_i,
  output logic                    done_o,
  output logic signed [AVG_W-1:0] quot_o
);

  localparam int unsigned ITER_W = $clog2(SUM_W + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0]  mag_q, mag_d;
  logic [CNT_W:0]    rem_q, rem_d;
  logic [CNT_W-1:0]  den_q, den_d;
  logic              neg_q, neg_d;
  logic [CNT_W:0]    trial;
  logic [SUM_W:0]    quot_full;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    trial  = {rem_q[CNT_W-1:0], mag_q[SUM_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = ITER_W'(SUM_W);
      neg_d  = num_i[SUM_W-1];
      mag_d  = num_i[SUM_W-1] ? SUM_W'(-num_i) : SUM_W'(num_i);
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        mag_d = {mag_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = trial;
        mag_d = {mag_q[SUM_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign quot_full = neg_q ? -{1'b0, mag_q} : {1'b0, mag_q};
  assign quot_o    = AVG_W'(quot_full);
  assign done_o    = done_q;

endmodule

FILE: rtl/adaptive_scene_cut_detector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_scene_cut_detector
// Sliding window of frame scores held in a rotating row of cells; the centre
// frame is tested against the rounded average of its neighbours.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | input     | in_valid_i / in_stall_o | in_data_i   (asc_in_t)
//  out     | output    | out_valid_o/ out_stall_i| out_data_o  (asc_out_t)
//  cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
//  Beats that test nothing (ignored frame, short window) answer directly.
//  A tested beat holds the input for one full rotation of the cell row for
//  the neighbour sum, then the serial divider, a multiply, a compare and the
//  write-out, which on a frame test drops the oldest entry.
//  Reset restores the register defaults and clears control state, the fill
//  count and the last cut record; window cells and datapath are not reset.
//  The input stalls while a beat is being tested, and while a held result
//  is stalled on the output side.
// ----------------------------------------------------------------------------
module adaptive_scene_cut_detector
  import asc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  asc_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output asc_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SUM, ST_PREP, ST_DIV, ST_MUL, ST_CMP, ST_DONE
  } state_e;

  // configuration
  logic [3:0]         half_width_q;
  logic [62:0]        min_scene_q;
  logic signed [31:0] min_score_q;
  logic [30:0]        ratio_q;

  state_e              state_q;
  logic [CNT_W-1:0]    fill_q;
  logic [CNT_W-1:0]    pos_q;
  logic [CNT_W-1:0]    centre_q;
  logic [CNT_W-1:0]    nbr_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                flush_q;
  logic                any_q;
  logic [47:0]         last_index_q;
  logic [62:0]         last_time_q;
  asc_entry_t          cen_q;
  logic signed [AVG_W-1:0] avg_q;
  logic signed [AVG_W+31:0] prod_q;
  logic signed [41:0]  s1000_q;
  logic                pass_q;
  logic                out_valid_q;
  logic                out_valid_d;
  asc_out_t            out_q;

  logic [CNT_W-1:0] w_eff;
  logic [CNT_W-1:0] need;
  logic             in_fire;
  logic             out_free;
  logic             frame_fire;
  logic             test_start;
  logic [CNT_W-1:0] fill_eff;
  logic [CNT_W-1:0] fill_new;
  logic [CNT_W-1:0] lo;
  logic [CNT_W:0]   hi_raw;
  logic [CNT_W:0]   hi;
  logic             in_range;
  logic             rotate;
  logic             div_start;
  logic             div_done;
  logic signed [AVG_W-1:0] div_quot;
  logic signed [SUM_W-1:0] div_num;
  logic [63:0]      time_diff;
  logic             pass_d;
  asc_out_t         cut_res;

  asc_entry_t     cell_out [DEPTH];
  asc_entry_t     new_entry;
  asc_cell_ctrl_t cell_ctrl [DEPTH];

  assign w_eff = (half_width_q > 4'(MAX_HALF_WIDTH)) ? CNT_W'(MAX_HALF_WIDTH)
                                                     : CNT_W'(half_width_q);
  assign need  = CNT_W'({w_eff, 1'b1});

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign frame_fire = in_fire && (in_data_i.opcode == OP_FRAME) && in_data_i.metrics_ok;

  // a full window drops its oldest entry before taking the new one
  assign fill_eff = (fill_q == CNT_W'(DEPTH)) ? CNT_W'(DEPTH - 1) : fill_q;
  assign fill_new = fill_eff + 1'b1;

  // accepted beat that needs a centre test; all others answer at once
  assign test_start = (in_data_i.opcode == OP_FLUSH) ? (fill_q > CNT_W'(1))
                                                     : (in_data_i.metrics_ok &&
                                                        (fill_new >= need));

  // set on a direct answer or a finished test, hold while stalled
  assign out_valid_d = (in_fire && !test_start) ||
                       (state_q == ST_DONE && out_free) ||
                       (out_valid_q && out_stall_i);

  assign new_entry = '{score:   in_data_i.frame_score,
                       time_us: in_data_i.frame_time_us,
                       index:   in_data_i.frame_index,
                       luma:    in_data_i.luma_delta,
                       hue:     in_data_i.hue_delta,
                       sat:     in_data_i.sat_delta};

  // rotate in the sum pass; to drop the oldest entry, also after a frame
  // test and on a frame into a full window; cell 0 wraps around to the last
  assign rotate = (state_q == ST_SUM) ||
                  (state_q == ST_DONE && out_free && !flush_q) ||
                  (frame_fire && fill_q == CNT_W'(DEPTH));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_ctrl[i].shift = rotate;
    assign cell_ctrl[i].load  = frame_fire && (fill_eff == CNT_W'(i));
    asc_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[i]),
      .next_i  (cell_out[(i + 1) % DEPTH]),
      .new_i   (new_entry),
      .entry_o (cell_out[i])
    );
  end

  // neighbour span around the centre, clipped to the fill
  assign lo       = (centre_q > w_eff) ? centre_q - w_eff : '0;
  assign hi_raw   = {1'b0, centre_q} + {1'b0, w_eff} + 1'b1;
  assign hi       = (hi_raw < {1'b0, fill_q}) ? hi_raw : {1'b0, fill_q};
  assign in_range = (pos_q >= lo) && ({1'b0, pos_q} < hi) && (pos_q != centre_q);

  assign div_num   = sum_q + SUM_W'(nbr_q >> 1);
  assign div_start = (state_q == ST_PREP);

  asc_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (nbr_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign time_diff = {1'b0, cen_q.time_us} - {1'b0, last_time_q};

  always_comb begin
    pass_d = 1'b1;
    if (any_q && (cen_q.index <= last_index_q)) pass_d = 1'b0;
    if (any_q && (time_diff < {1'b0, min_scene_q})) pass_d = 1'b0;
    if (cen_q.score < min_score_q) pass_d = 1'b0;
    if (nbr_q == '0) pass_d = 1'b0;
    if (avg_q == '0) begin
      if (cen_q.score <= 32'sd0) pass_d = 1'b0;
    end else if ((AVG_W+32)'(s1000_q) < prod_q) begin
      pass_d = 1'b0;
    end
  end

  // cut event built from the captured centre entry
  always_comb begin
    cut_res               = '0;
    cut_res.cut_found     = 1'b1;
    cut_res.cut_time_us   = cen_q.time_us;
    cut_res.cut_index     = cen_q.index;
    cut_res.cut_score     = cen_q.score;
    cut_res.cut_threshold = ratio_q;
    cut_res.cut_luma      = cen_q.luma;
    cut_res.cut_hue       = cen_q.hue;
    cut_res.cut_sat       = cen_q.sat;
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_width_q <= 4'd2;
      min_scene_q  <= '0;
      min_score_q  <= '0;
      ratio_q      <= 31'd3000;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HALF_WIDTH:   half_width_q <= cfg_wdata_i[3:0];
        CFG_MIN_SCENE_US: min_scene_q  <= cfg_wdata_i;
        CFG_MIN_SCORE:    min_score_q  <= cfg_wdata_i[31:0];
        CFG_RATIO:        ratio_q      <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  // sequencer: state and registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fill_q       <= '0;
      pos_q        <= '0;
      centre_q     <= '0;
      nbr_q        <= '0;
      flush_q      <= 1'b0;
      any_q        <= 1'b0;
      last_index_q <= '0;
      last_time_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            pos_q <= '0;
            nbr_q <= '0;
            if (in_data_i.opcode == OP_FLUSH) begin
              if (fill_q > CNT_W'(1)) begin
                centre_q <= fill_q >> 1;
                flush_q  <= 1'b1;
                state_q  <= ST_SUM;
              end else begin
                fill_q <= '0;
              end
            end else if (in_data_i.metrics_ok) begin
              fill_q <= fill_new;
              if (fill_new >= need) begin
                centre_q <= w_eff;
                flush_q  <= 1'b0;
                state_q  <= ST_SUM;
              end
            end
            // ignored frame: empty result, window and fill unchanged
          end
        end
        ST_SUM: begin
          if (in_range && (pos_q < fill_q)) nbr_q <= nbr_q + 1'b1;
          pos_q <= pos_q + 1'b1;
          if (pos_q == CNT_W'(DEPTH - 1)) state_q <= ST_PREP;
        end
        ST_PREP: state_q <= ST_DIV;
        ST_DIV:  if (div_done) state_q <= ST_MUL;
        ST_MUL:  state_q <= ST_CMP;
        ST_CMP:  state_q <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            if (pass_q) begin
              any_q        <= 1'b1;
              last_index_q <= cen_q.index;
              last_time_q  <= cen_q.time_us;
            end
            fill_q  <= flush_q ? '0 : fill_q - 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) sum_q <= '0;
    if (state_q == ST_SUM) begin
      if (in_range && (pos_q < fill_q)) sum_q <= sum_q + SUM_W'(cell_out[0].score);
      if (pos_q == centre_q) cen_q <= cell_out[0];
    end
    if (div_done) avg_q <= div_quot;
    if (state_q == ST_MUL) begin
      prod_q  <= $signed({1'b0, ratio_q}) * avg_q;
      s1000_q <= cen_q.score * 42'sd1000;
    end
    if (state_q == ST_CMP) pass_q <= pass_d;
    if (in_fire) out_q <= '0;
    if (state_q == ST_DONE && out_free) out_q <= pass_q ? cut_res : '0;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("input taken while a test is running");
  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide step");
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_W'(DEPTH))
    else $error("window fill beyond depth");
  a_done_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> out_valid_q)
    else $error("finished test produced no result");
`endif

endmodule
